// File: src/bba_pkg.sv
package bba_pkg;

  localparam int ORDERS    = 11;
  localparam int MAXB      = 1 << (ORDERS - 1);
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = 68;
  localparam int AW        = 7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_BAD_ARG = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_A_RD, S_A_EVAL, S_S_CHK, S_S_RD, S_S_EVAL,
    S_F_RD, S_F_EVAL, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_PRE_ERR, OP_A_INIT, OP_F_INIT, OP_A_EVAL,
    OP_S_PREP, OP_S_EVAL, OP_F_EVAL, OP_NOFREE, OP_OK, OP_PUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic pre_err;
    logic a_hit;
    logic a_last;
    logic k_top;
    logic split_done;
    logic f_done;
    logic out_free;
  } stat_t;

  // first word of each order's bitmap
  function automatic logic [AW-1:0] base_word(input logic [3:0] k);
    case (k)
      4'd0:    base_word = 7'd0;
      4'd1:    base_word = 7'd32;
      4'd2:    base_word = 7'd48;
      4'd3:    base_word = 7'd56;
      4'd4:    base_word = 7'd60;
      4'd5:    base_word = 7'd62;
      4'd6:    base_word = 7'd63;
      4'd7:    base_word = 7'd64;
      4'd8:    base_word = 7'd65;
      4'd9:    base_word = 7'd66;
      4'd10:   base_word = 7'd67;
      default: base_word = 7'd0;
    endcase
  endfunction

  function automatic logic [4:0] last_word(input logic [3:0] k);
    if (k < 4'd5) last_word = 5'(6'd32 >> k) - 5'd1;
    else          last_word = 5'd0;
  endfunction

  // word contents right after the pool has been cut into chunks
  function automatic logic [WORD_BITS-1:0] init_word(input logic [3:0] k,
                                                     input logic [4:0] w,
                                                     input logic [10:0] pool);
    logic [10:0] i;
    i = (pool >> k) & 11'h7FE;
    init_word = '0;
    if (pool[k] && i[9:5] == w) init_word[i[4:0]] = 1'b1;
  endfunction

  function automatic logic [4:0] lsb32(input logic [WORD_BITS-1:0] v);
    lsb32 = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) lsb32 = 5'(b);
    end
  endfunction

endpackage

// File: src/bba_ctrl.sv
module bba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pre_err) begin
          cmd.op     = OP_PRE_ERR;
          state_next = S_OUT;
        end else if (stat.is_free) begin
          cmd.op     = OP_F_INIT;
          state_next = S_F_RD;
        end else begin
          cmd.op     = OP_A_INIT;
          state_next = S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_EVAL;
      S_A_EVAL: begin
        if (stat.a_hit) begin
          cmd.op     = OP_A_EVAL;
          state_next = S_S_CHK;
        end else if (stat.a_last && stat.k_top) begin
          cmd.op     = OP_NOFREE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_A_EVAL;
          state_next = S_A_RD;
        end
      end
      S_S_CHK: begin
        if (stat.split_done) begin
          cmd.op     = OP_OK;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_S_PREP;
          state_next = S_S_RD;
        end
      end
      S_S_RD: state_next = S_S_EVAL;
      S_S_EVAL: begin
        cmd.op     = OP_S_EVAL;
        state_next = S_S_CHK;
      end
      S_F_RD: state_next = S_F_EVAL;
      S_F_EVAL: begin
        cmd.op     = OP_F_EVAL;
        state_next = stat.f_done ? S_OUT : S_F_RD;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/bba_datapath.sv
module bba_datapath (
  input  logic           clk,
  input  logic           rst,
  input  bba_pkg::cmd_t  cmd,
  output bba_pkg::stat_t stat,
  input  logic           req_type,
  input  logic [10:0]    request_blocks,
  input  logic [9:0]     free_offset,
  input  logic [3:0]     free_order,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_data,
  output logic [10:0]    total_blocks,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [15:0]    res_data
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 rv_q;
  logic [NUM_WORDS-1:0] wvalid;

  logic        typ;
  logic [10:0] reqb;
  logic [9:0]  foff;
  logic [3:0]  ford;
  logic [3:0]  need;
  logic [3:0]  k;
  logic [9:0]  off;
  logic [4:0]  w;
  logic        first;
  logic [1:0]  code;

  logic [10:0]          pool;
  logic [AW-1:0]        addr;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;
  logic [9:0]           idx;
  logic [4:0]           hit_pos;
  logic [3:0]           need_c;
  logic [1:0]           pre_code;
  logic [11:0]          fend;
  logic                 own, bud;
  logic [3:0]           k_dn, k_up;
  logic [9:0]           off_up, idx_dn, idx_up;

  assign pool = (total_blocks > 11'(MAXB)) ? 11'(MAXB) : total_blocks;
  assign addr = base_word(k) + AW'(w);
  assign word = rv_q ? rd_q : init_word(k, w, pool);
  assign idx  = off >> k;
  assign hit_pos = lsb32(word);
  assign own = word[idx[4:0]];
  assign bud = word[idx[4:0] ^ 5'd1];

  assign k_dn   = k - 4'd1;
  assign idx_dn = off >> k_dn;
  assign k_up   = k + 4'd1;
  assign off_up = off & ~(10'd1 << k);
  assign idx_up = off_up >> k_up;

  always_comb begin
    need_c = '0;
    for (int i = 0; i < ORDERS; i++) begin
      if ((12'd1 << i) < {1'b0, reqb}) need_c = need_c + 4'd1;
    end
  end

  assign fend = {2'b0, foff} + (12'd1 << ford);

  always_comb begin
    pre_code = ST_OK;
    if (typ == REQ_ALLOC) begin
      if (reqb == 11'd0)             pre_code = ST_BAD_ARG;
      else if (reqb > 11'(MAXB))     pre_code = ST_TOO_BIG;
    end else begin
      if (ford >= 4'(ORDERS))                         pre_code = ST_BAD_ARG;
      else if ((foff & ~(10'h3FF << ford)) != 10'd0)  pre_code = ST_BAD_ARG;
      else if (fend > {1'b0, pool})                   pre_code = ST_BAD_ARG;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = word;
    case (cmd.op)
      OP_A_EVAL: begin
        if (word != '0) begin
          we             = 1'b1;
          wdata[hit_pos] = 1'b0;
        end
      end
      OP_S_EVAL: begin
        we                     = 1'b1;
        wdata[{idx[4:1], 1'b1}] = 1'b1;
      end
      OP_F_EVAL: begin
        if (first && own) begin
          we = 1'b0;
        end else if (bud && k != 4'(ORDERS - 1)) begin
          we                       = 1'b1;
          wdata[idx[4:0] ^ 5'd1]   = 1'b0;
        end else begin
          we                = 1'b1;
          wdata[idx[4:0]]   = 1'b1;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      wvalid <= '0;
      rv_q   <= 1'b0;
    end else begin
      if (we) wvalid[addr] <= 1'b1;
      rv_q <= wvalid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)         total_blocks <= 11'(MAXB);
    else if (cfg_we) total_blocks <= cfg_data;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        typ  <= req_type;
        reqb <= request_blocks;
        foff <= free_offset;
        ford <= free_order;
      end
      OP_PRE_ERR: code <= pre_code;
      OP_A_INIT: begin
        need <= need_c;
        k    <= need_c;
        w    <= '0;
      end
      OP_F_INIT: begin
        k     <= ford;
        off   <= foff;
        w     <= 5'((foff >> ford) >> 5);
        first <= 1'b1;
      end
      OP_A_EVAL: begin
        if (word != '0) begin
          off <= 10'({w, hit_pos} << k);
        end else if (w == last_word(k)) begin
          k <= k + 4'd1;
          w <= '0;
        end else begin
          w <= w + 5'd1;
        end
      end
      OP_S_PREP: begin
        k <= k_dn;
        w <= idx_dn[9:5];
      end
      OP_F_EVAL: begin
        first <= 1'b0;
        if (first && own) begin
          code <= ST_BAD_ARG;
        end else if (bud && k != 4'(ORDERS - 1)) begin
          off <= off_up;
          k   <= k_up;
          w   <= idx_up[9:5];
        end else begin
          code <= ST_OK;
        end
      end
      OP_NOFREE: code <= ST_NO_FREE;
      OP_OK:     code <= ST_OK;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      if (code == ST_OK) res_data <= {k, off, code};
      else               res_data <= {14'd0, code};
    end
  end

  assign stat.is_free    = (typ == REQ_FREE);
  assign stat.pre_err    = (pre_code != ST_OK);
  assign stat.a_hit      = (word != '0);
  assign stat.a_last     = (w == last_word(k));
  assign stat.k_top      = (k == 4'(ORDERS - 1));
  assign stat.split_done = (k == need);
  assign stat.f_done     = (first && own) || !(bud && k != 4'(ORDERS - 1));
  assign stat.out_free   = !res_valid || res_ready;

endmodule

// File: src/buddy_block_allocator_core.sv
// Channel   Direction  Transaction
// s_*       in         request: tuser req_type, tdata size/offset/order
// m_*       out        result: status, block offset, block order
// APB       in         total_blocks at address 0
//
// One request at a time. A request refused up front goes straight to the
// result; a granted allocate reads and evaluates bitmap words in turn (up to
// 68 words over all orders) and then splits one level per read-and-write step;
// an allocate that finds no free block ends after its scan; a free reads and
// evaluates one order per merge step. The controller passes through idle before
// the next request is taken. The single-port bitmap memory (one 32-bit word per
// access, read then written) paces each of these steps.
// Reset (synchronous, active high) and each pool size write restore the
// chunked pool at once through per-word valid flags; no clearing pass.
// A stalled result sits in the output register; the next request waits for
// it only at the very end of its own work.
module buddy_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_blocks[10:0], free_offset[20:11], free_order[24:21]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], block_offset[11:2], block_order[15:12]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bba_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic        cfg_we;
  logic [10:0] total_blocks;

  // write the pool size on the APB access phase when paddr[2] is clear; other addresses drop
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, total_blocks} : 32'd0;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (s_tuser),
    .request_blocks (s_tdata[10:0]),
    .free_offset    (s_tdata[20:11]),
    .free_order     (s_tdata[24:21]),
    .cfg_we         (cfg_we),
    .cfg_data       (pwdata[10:0]),
    .total_blocks   (total_blocks),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_data       (m_tdata)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  import bba_pkg::*;

  // Clock and reset
  logic        clk = 1'b0;
  logic        rst = 1'b1;

  // Request stream (slave side of the block)
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // request_blocks[10:0], free_offset[20:11], free_order[24:21]
  logic        s_tuser = 1'b0; // req_type

  // Result stream (master side of the block)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[1:0], block_offset[11:2], block_order[15:12]

  // Register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // laid out as m_tdata: status in the lowest bits
  typedef struct packed {
    logic [3:0] order;
    logic [9:0] offset;
    logic [1:0] status;
  } grant_t;

  typedef struct packed {
    logic [9:0] offset;
    logic [3:0] order;
  } held_t;

  // Predictor state: one free bit per aligned block of each order
  bit          free_bits [ORDERS][MAXB];
  int unsigned pool_size;
  grant_t      grant_q[$];   // expected results, oldest first
  held_t       held_q[$];    // blocks currently handed out, used to build legal frees

  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  buddy_block_allocator_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Cut the pool into power-of-two chunks, largest first at the lowest offsets.
  function automatic void rebuild_pool(int unsigned size);
    int unsigned left, off;
    pool_size = (size > MAXB) ? MAXB : size;
    left = pool_size;
    off = 0;
    foreach (free_bits[k, i]) free_bits[k][i] = 1'b0;
    for (int k = ORDERS - 1; k >= 0; k--) begin
      if (left >= (1 << k)) begin
        free_bits[k][off >> k] = 1'b1;
        off += (1 << k);
        left -= (1 << k);
      end
    end
    held_q.delete();
  endfunction

  // Work out the grant for one request and advance the free bitmap.
  function automatic grant_t grant_for(logic kind, int unsigned blocks,
                                       int unsigned foff, int unsigned ford);
    grant_t g;
    int unsigned need, off, k;
    bit found;
    g = '{status: ST_BAD_ARG, offset: '0, order: '0};
    if (kind == REQ_ALLOC) begin
      if (blocks == 0) return g;
      if (blocks > MAXB) begin
        g.status = ST_TOO_BIG;
        return g;
      end
      need = 0;
      while ((1 << need) < blocks) need++;
      found = 1'b0;
      for (k = need; k < ORDERS; k++) begin
        for (int i = 0; i < (MAXB >> k); i++) begin
          if (free_bits[k][i]) begin
            off = i << k;
            found = 1'b1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) begin
        g.status = ST_NO_FREE;
        return g;
      end
      free_bits[k][off >> k] = 1'b0;
      // free the upper half of every level split off on the way down
      for (int j = k; j > need; j--) free_bits[j-1][(off + (1 << (j-1))) >> (j-1)] = 1'b1;
      g = '{status: ST_OK, offset: off[9:0], order: need[3:0]};
    end else begin
      if (ford >= ORDERS) return g;
      if ((foff & ((1 << ford) - 1)) != 0) return g;
      if (foff + (1 << ford) > pool_size) return g;
      if (free_bits[ford][foff >> ford]) return g;
      k = ford;
      off = foff;
      // climb while the buddy at this order is free
      while (k + 1 < ORDERS && free_bits[k][(off ^ (1 << k)) >> k]) begin
        free_bits[k][(off ^ (1 << k)) >> k] = 1'b0;
        off &= ~(1 << k);
        k++;
      end
      free_bits[k][off >> k] = 1'b1;
      g = '{status: ST_OK, offset: off[9:0], order: k[3:0]};
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one request: idle at random, then hold tvalid until the transaction.
  task automatic send_request(logic kind, int unsigned blocks,
                              int unsigned foff, int unsigned ford);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'b0, ford[3:0], foff[9:0], blocks[10:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = grant_for(kind, blocks, foff, ford);
    grant_q.push_back(g);
    if (kind == REQ_ALLOC && g.status == ST_OK) held_q.push_back('{g.offset, g.order});
  endtask

  // Drop tvalid and hold until every expected result is back, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase; only called while the block is idle.
  task automatic write_pool_size(int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rebuild_pool(value & 32'h7FF);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction against the oldest expectation.
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, -1);
      end else begin
        want = grant_q.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.offset != want.offset) report_mismatch("block_offset", got.offset, want.offset);
        if (got.order != want.order) report_mismatch("block_order", got.order, want.order);
      end
    end
  end

  // Watchdog: end the run after too long without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Field extremes, every error class, double free and a full merge back up.
  task automatic test_directed();
    send_request(REQ_ALLOC, 0, 0, 0);        // zero size
    send_request(REQ_ALLOC, 1025, 0, 0);     // too large
    send_request(REQ_ALLOC, 2047, 1023, 15); // too large, all bits set
    send_request(REQ_ALLOC, 1, 0, 0);
    send_request(REQ_ALLOC, 3, 0, 0);        // rounds up to 4
    send_request(REQ_ALLOC, 1024, 0, 0);     // no free block left that large
    send_request(REQ_FREE, 0, 0, 11);        // order out of range
    send_request(REQ_FREE, 0, 0, 15);
    send_request(REQ_FREE, 0, 2, 2);         // misaligned
    send_request(REQ_FREE, 0, 1023, 0);      // inside a free block, yet accepted: only its own bit is checked
    send_request(REQ_FREE, 0, 0, 0);         // frees the unit block and merges
    send_request(REQ_FREE, 0, 0, 0);         // double free of a merged block
    send_request(REQ_FREE, 0, 4, 2);         // merges back to the whole pool
    send_request(REQ_ALLOC, 1024, 0, 0);
    send_request(REQ_ALLOC, 1, 0, 0);        // still granted from a stray unit bit left by the accepted double frees
    send_request(REQ_FREE, 0, 0, 10);
    drain();
    // smaller pool: frees past the end are refused
    write_pool_size(700);
    send_request(REQ_FREE, 0, 512, 8);
    send_request(REQ_FREE, 0, 704, 6);
    send_request(REQ_ALLOC, 512, 0, 0);
    send_request(REQ_ALLOC, 512, 0, 0);
    send_request(REQ_FREE, 0, 0, 9);
    drain();
    write_pool_size(0);                      // empty pool
    send_request(REQ_ALLOC, 1, 0, 0);
    send_request(REQ_FREE, 0, 0, 0);
    drain();
    write_pool_size(2047);                   // saturates to the largest pool
    send_request(REQ_ALLOC, 1024, 0, 0);
    send_request(REQ_FREE, 0, 0, 10);
    drain();
  endtask

  // Mostly legal alloc/free traffic over live blocks, with some noise.
  task automatic test_random(int count, int s_idle, int r_idle);
    int unsigned pick, sz;
    held_t h;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // small sizes mostly, now and then a large one
        sz = ($urandom_range(9) == 0) ? $urandom_range(1024, 1) : $urandom_range(40, 1);
        send_request(REQ_ALLOC, sz, $urandom_range(1023), $urandom_range(15));
      end else if (pick < 88 && held_q.size() != 0) begin
        h = held_q[$urandom_range(held_q.size() - 1)];
        foreach (held_q[i]) if (held_q[i] == h) begin
          held_q.delete(i);
          break;
        end
        send_request(REQ_FREE, $urandom_range(2047), h.offset, h.order);
      end else begin
        send_request(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(1023),
                     $urandom_range(15));
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    rebuild_pool(1024);
    test_directed();
    write_pool_size($urandom_range(1024, 1));
    test_random(450, 8, 54);
    write_pool_size(1);
    test_random(30, 0, 0);
    write_pool_size(1024);
    test_random(450, 54, 8);
    write_pool_size($urandom_range(1023, 513));
    test_random(450, 0, 0);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
src/bba_pkg.sv
src/bba_ctrl.sv
src/bba_datapath.sv
src/buddy_block_allocator_core.sv
tb/tb_top.sv
